/* rtl/sat_pkg.sv */
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types and codes of the section address translator: the command and
// result words, the stored section entry and the register map.
// ----------------------------------------------------------------------------
package sat_pkg;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_XLATE = 1'b1;

	localparam logic [1:0] KIND_VA  = 2'd0;
	localparam logic [1:0] KIND_RVA = 2'd1;
	localparam logic [1:0] KIND_FO  = 2'd2;

	localparam int unsigned PADDR_W = 3;
	localparam logic REG_IMAGE_BASE    = 1'b0;
	localparam logic REG_SECTION_COUNT = 1'b1;

	typedef struct packed {
		logic        op;
		logic [3:0]  entry_index;
		logic [31:0] entry_virt_start;
		logic [31:0] entry_virt_size;
		logic [31:0] entry_raw_start;
		logic [31:0] entry_raw_size;
		logic [1:0]  addr_kind;
		logic [31:0] query_addr;
	} cmd_word_t;

	typedef struct packed {
		logic [3:0]  section_index;
		logic        hit;
		logic [31:0] virt_addr;
		logic [31:0] rel_virt_addr;
		logic [31:0] file_offset;
	} result_word_t;

	typedef struct packed {
		logic [31:0] virt_start;
		logic [31:0] virt_size;
		logic [31:0] raw_start;
		logic [31:0] raw_size;
	} sect_entry_t;

endpackage

/* rtl/sat_sect_ram.sv */
// ----------------------------------------------------------------------------
// sat_sect_ram
// Section descriptor table: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module sat_sect_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  sat_pkg::sect_entry_t wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output sat_pkg::sect_entry_t rd_data
);

	sat_pkg::sect_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/section_address_translator.sv */
// ----------------------------------------------------------------------------
// section_address_translator
// Translates an address given as a virtual address, a relative virtual address
// or a file offset through a table of section descriptors.
//
//   Channel   Signals                                   Handshake
//   command   start, busy, cmd                          start && !busy
//   result    done, result                              done, one cycle
//   config    psel, penable, pwrite, paddr, pwdata,      write in access phase
//             prdata, pready
//
// A write word leaves the translator idle. A translate word walks the table,
// reading one entry per cycle from the section memory, and stops at the
// first match or after the last counted entry; a count of zero skips the
// walk. An unknown address kind answers in the cycle after it is accepted.
// Reset clears the registers and the controller; the table holds no value
// until written. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module section_address_translator #(
	parameter int unsigned MAX_SECTIONS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  sat_pkg::cmd_word_t             cmd,
	output logic                           done,
	output sat_pkg::result_word_t          result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sat_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	localparam int unsigned CW  = $clog2(MAX_SECTIONS + 1);
	localparam int unsigned IW  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int unsigned IXW = (CW > 4) ? CW : 4;
	localparam int unsigned SW  = (CW > 5) ? CW : 5;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_SEARCH  = 7'b0000010,
		ST_ZERO_RD = 7'b0000100,
		ST_ZERO_LD = 7'b0001000,
		ST_FIN1    = 7'b0010000,
		ST_FIN2    = 7'b0100000,
		ST_FIN3    = 7'b1000000
	} state_t;

	state_t state_q;
	logic [31:0] image_base_q;
	logic [4:0]  section_count_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] issue_q;
	logic          rd_vld_s1;
	logic [CW-1:0] rd_idx_s1;
	logic          vld_s2;
	logic [CW-1:0] idx_s2;
	logic [31:0]   lo_s2;
	logic [31:0]   size_s2;
	logic [31:0]   vs_s2;
	logic [31:0]   rs_s2;
	logic          done_q;
	logic          hit_q;
	logic [CW-1:0] sel_idx_q;
	logic [31:0]   sel_vs_q;
	logic [31:0]   sel_rs_q;
	logic [1:0]    kind_q;
	logic [31:0]   addr_q;
	logic [31:0]   va_q;
	logic [31:0]   rva_q;
	logic [31:0]   fo_q;
	logic [31:0]   tmp_q;
	sat_pkg::result_word_t result_q;

	logic          accept;
	logic          cfg_wr;
	logic [SW-1:0] sc_ext;
	logic [CW-1:0] cnt_eff;
	logic [IXW-1:0] widx;
	logic          wr_en;
	logic          kind_ok;
	logic          first_issue;
	logic          m_s2;
	logic          last_s2;
	logic          hit_now;
	logic          miss_now;
	logic          search_go;
	logic          srch_issue;
	logic          rd_en;
	logic [CW-1:0] rd_idx;
	logic [31:0]   hi_s2;
	sat_pkg::sect_entry_t wr_entry;
	sat_pkg::sect_entry_t rd_data;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		if (paddr[2] == sat_pkg::REG_IMAGE_BASE) begin
			prdata = image_base_q;
		end else begin
			prdata = {27'd0, section_count_q};
		end
	end

	assign sc_ext  = SW'(section_count_q);
	assign cnt_eff = (sc_ext > SW'(MAX_SECTIONS)) ? CW'(MAX_SECTIONS) : CW'(sc_ext);

	assign widx  = IXW'(cmd.entry_index);
	assign wr_en = accept && (cmd.op == sat_pkg::OP_WRITE) && (widx < IXW'(MAX_SECTIONS));
	assign wr_entry.virt_start = cmd.entry_virt_start;
	assign wr_entry.virt_size  = cmd.entry_virt_size;
	assign wr_entry.raw_start  = cmd.entry_raw_start;
	assign wr_entry.raw_size   = cmd.entry_raw_size;

	assign kind_ok     = (cmd.addr_kind == sat_pkg::KIND_VA) || (cmd.addr_kind == sat_pkg::KIND_RVA)
		|| (cmd.addr_kind == sat_pkg::KIND_FO);
	assign first_issue = accept && (cmd.op == sat_pkg::OP_XLATE) && kind_ok && (cnt_eff != '0);

	assign hi_s2     = lo_s2 + size_s2;
	assign m_s2      = vld_s2 && (addr_q >= lo_s2) && (addr_q <= hi_s2);
	assign last_s2   = vld_s2 && (idx_s2 == (cnt_q - CW'(1)));
	assign hit_now   = (state_q == ST_SEARCH) && m_s2;
	assign miss_now  = (state_q == ST_SEARCH) && !m_s2 && last_s2;
	assign search_go = (state_q == ST_SEARCH) && !m_s2 && !last_s2;

	assign srch_issue = first_issue || (search_go && (issue_q < cnt_q));
	assign rd_en      = srch_issue || (state_q == ST_ZERO_RD);
	assign rd_idx     = (state_q == ST_SEARCH) ? issue_q : '0;

	sat_sect_ram #(
		.DEPTH (MAX_SECTIONS),
		.AW    (IW)
	) u_sat_sect_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (widx[IW-1:0]),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_idx[IW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			image_base_q    <= '0;
			section_count_q <= '0;
			cnt_q           <= '0;
			issue_q         <= '0;
			rd_vld_s1       <= 1'b0;
			vld_s2          <= 1'b0;
			done_q          <= 1'b0;
			hit_q           <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == sat_pkg::REG_IMAGE_BASE) begin
					image_base_q <= pwdata;
				end else begin
					section_count_q <= pwdata[4:0];
				end
			end
			rd_vld_s1 <= srch_issue;
			vld_s2    <= rd_vld_s1 && search_go;
			done_q    <= (state_q == ST_FIN3)
				|| (accept && (cmd.op == sat_pkg::OP_XLATE) && !kind_ok);
			if (srch_issue) begin
				issue_q <= rd_idx + CW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (cmd.op == sat_pkg::OP_XLATE)) begin
						cnt_q <= cnt_eff;
						hit_q <= 1'b0;
						if (kind_ok) begin
							if (cnt_eff == '0) begin
								state_q <= ST_ZERO_RD;
							end else begin
								state_q <= ST_SEARCH;
							end
						end
					end
				end
				ST_SEARCH: begin
					if (hit_now) begin
						hit_q   <= 1'b1;
						state_q <= ST_FIN1;
					end else if (miss_now) begin
						state_q <= ST_ZERO_RD;
					end
				end
				ST_ZERO_RD: state_q <= ST_ZERO_LD;
				ST_ZERO_LD: state_q <= ST_FIN1;
				ST_FIN1:    state_q <= ST_FIN2;
				ST_FIN2:    state_q <= ST_FIN3;
				ST_FIN3:    state_q <= ST_IDLE;
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx;
		idx_s2    <= rd_idx_s1;
		vs_s2     <= rd_data.virt_start;
		rs_s2     <= rd_data.raw_start;
		if (kind_q == sat_pkg::KIND_FO) begin
			lo_s2   <= rd_data.raw_start;
			size_s2 <= rd_data.raw_size;
		end else if (kind_q == sat_pkg::KIND_VA) begin
			lo_s2   <= image_base_q + rd_data.virt_start;
			size_s2 <= rd_data.virt_size;
		end else begin
			lo_s2   <= rd_data.virt_start;
			size_s2 <= rd_data.virt_size;
		end

		if (accept) begin
			kind_q   <= cmd.addr_kind;
			addr_q   <= cmd.query_addr;
			result_q <= '0;
		end
		if (hit_now) begin
			sel_idx_q <= idx_s2;
			sel_vs_q  <= vs_s2;
			sel_rs_q  <= rs_s2;
		end
		if (state_q == ST_ZERO_LD) begin
			sel_idx_q <= '0;
			sel_vs_q  <= rd_data.virt_start;
			sel_rs_q  <= rd_data.raw_start;
		end

		if (state_q == ST_FIN1) begin
			unique case (kind_q)
				sat_pkg::KIND_VA: begin
					va_q  <= addr_q;
					rva_q <= addr_q - image_base_q;
				end
				sat_pkg::KIND_RVA: begin
					rva_q <= addr_q;
					va_q  <= addr_q + image_base_q;
				end
				default: begin
					fo_q  <= addr_q;
					tmp_q <= addr_q - sel_rs_q;
				end
			endcase
		end
		if (state_q == ST_FIN2) begin
			if (kind_q == sat_pkg::KIND_FO) begin
				rva_q <= sel_vs_q + tmp_q;
			end else begin
				tmp_q <= rva_q - sel_vs_q;
			end
		end
		if (state_q == ST_FIN3) begin
			result_q.section_index <= 4'(sel_idx_q);
			result_q.hit           <= hit_q;
			result_q.rel_virt_addr <= rva_q;
			if (kind_q == sat_pkg::KIND_FO) begin
				result_q.virt_addr   <= rva_q + image_base_q;
				result_q.file_offset <= fo_q;
			end else begin
				result_q.virt_addr   <= va_q;
				result_q.file_offset <= sel_rs_q + tmp_q;
			end
		end
	end

endmodule

/* rtl/sat_checker.sv */
// ----------------------------------------------------------------------------
// sat_port_checker
// Port-level checks of the section address translator, bound to the top level.
// ----------------------------------------------------------------------------
module sat_port_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input sat_pkg::cmd_word_t    cmd,
	input logic                  done,
	input sat_pkg::result_word_t result,
	input logic                  pready
);

	// A result only follows a busy cycle or an accepted word.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result word without a preceding command");

	// The end of a translation always delivers its result.
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("translation ended without a result word");

	// A write word never produces a result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.op == sat_pkg::OP_WRITE)) |=> !done)
		else $error("write word produced a result");

	// A miss reports section zero.
	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result.section_index == 4'd0))
		else $error("miss reported a nonzero section");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("configuration port stalled");

endmodule

bind section_address_translator sat_port_checker u_sat_port_checker (.*);

/* tb/sv/sat_checker.sv */
// ----------------------------------------------------------------------------
// sat_checker
// Watches the command, result and register ports of the section address
// translator. It keeps its own copy of the section table and registers,
// predicts the result word of every accepted translate word, and compares the
// result words in order, field by field.
// ----------------------------------------------------------------------------
module sat_checker
	import sat_pkg::*;
#(
	parameter int unsigned NUM_SECTIONS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  cmd_word_t           cmd,
	input  logic                done,
	input  result_word_t        result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int unsigned         error_count,
	output int unsigned         pending
);

	logic [31:0]  image_base;
	logic [4:0]   section_count;
	sect_entry_t  sections [NUM_SECTIONS];
	result_word_t expected_results [$];

	function automatic logic contains(logic [31:0] a, logic [31:0] lo, logic [31:0] len);
		logic [31:0] hi;
		hi = lo + len;
		return (a >= lo) && (a <= hi);
	endfunction

	function automatic result_word_t translate_address(cmd_word_t c);
		result_word_t r;
		int unsigned  limit;
		logic [31:0]  lo;
		logic [31:0]  len;
		logic [3:0]   sel;
		logic         found;
		sect_entry_t  e;
		r = '0;
		sel = '0;
		found = 1'b0;
		limit = (section_count > NUM_SECTIONS) ? NUM_SECTIONS : section_count;
		if (c.addr_kind inside {KIND_VA, KIND_RVA, KIND_FO}) begin
			for (int unsigned i = 0; i < limit && !found; i++) begin
				e = sections[i];
				case (c.addr_kind)
					KIND_VA: begin
						lo = image_base + e.virt_start;
						len = e.virt_size;
					end
					KIND_RVA: begin
						lo = e.virt_start;
						len = e.virt_size;
					end
					default: begin
						lo = e.raw_start;
						len = e.raw_size;
					end
				endcase
				if (contains(c.query_addr, lo, len)) begin
					sel = i[3:0];
					found = 1'b1;
				end
			end
			e = sections[sel];
			case (c.addr_kind)
				KIND_VA: begin
					r.virt_addr = c.query_addr;
					r.rel_virt_addr = c.query_addr - image_base;
					r.file_offset = e.raw_start + (r.rel_virt_addr - e.virt_start);
				end
				KIND_RVA: begin
					r.rel_virt_addr = c.query_addr;
					r.virt_addr = c.query_addr + image_base;
					r.file_offset = e.raw_start + (r.rel_virt_addr - e.virt_start);
				end
				default: begin
					r.file_offset = c.query_addr;
					r.rel_virt_addr = e.virt_start + (c.query_addr - e.raw_start);
					r.virt_addr = r.rel_virt_addr + image_base;
				end
			endcase
			r.section_index = sel;
			r.hit = found;
		end
		return r;
	endfunction

	task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_word_t want;
		if (!arst_n) begin
			image_base = '0;
			section_count = '0;
			expected_results.delete();
			error_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_IMAGE_BASE, 2'b00}) begin
					image_base = pwdata;
				end else if (paddr == {REG_SECTION_COUNT, 2'b00}) begin
					section_count = pwdata[4:0];
				end
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result word with no translation outstanding");
					error_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("section_index", 32'(want.section_index),
						32'(result.section_index));
					compare_field("hit", 32'(want.hit), 32'(result.hit));
					compare_field("virt_addr", want.virt_addr, result.virt_addr);
					compare_field("rel_virt_addr", want.rel_virt_addr, result.rel_virt_addr);
					compare_field("file_offset", want.file_offset, result.file_offset);
				end
			end
			if (start && !busy) begin
				if (cmd.op == OP_WRITE) begin
					if (cmd.entry_index < NUM_SECTIONS) begin
						sections[cmd.entry_index] = {cmd.entry_virt_start, cmd.entry_virt_size,
							cmd.entry_raw_start, cmd.entry_raw_size};
					end
				end else begin
					expected_results.push_back(translate_address(cmd));
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Top of the section address translator bench. A directed run covers table
// bounds, wrapping sections, misses and the unknown address kind; random
// phases then load the table and translate addresses aimed at section edges
// under several register settings, with random gaps between command words.
// ----------------------------------------------------------------------------
module testbench;
	import sat_pkg::*;

	localparam int unsigned NUM_SECTIONS    = 16;
	localparam logic [1:0]  KIND_UNKNOWN    = 2'd3;
	localparam int unsigned NUM_PHASES      = 8;
	localparam int unsigned ITEMS_PER_PHASE = 200;
	localparam int unsigned SETTLE_CYCLES   = 40;
	localparam int unsigned QUIET_LIMIT     = 2000;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	cmd_word_t           cmd;
	logic                done;
	result_word_t        result;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	int unsigned         error_count;
	int unsigned         pending;
	int unsigned         quiet_cycles = 0;

	sect_entry_t              layout [NUM_SECTIONS];
	logic [NUM_SECTIONS-1:0]  loaded;
	logic [31:0]              base_now;
	logic [4:0]               count_now;
	logic                     idle_enabled;
	logic                     idle_allowed;

	section_address_translator #(.MAX_SECTIONS(NUM_SECTIONS)) DUT (.*);

	sat_checker #(.NUM_SECTIONS(NUM_SECTIONS)) xlate_check (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((start && !busy) || done || (psel && penable && pwrite && pready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles == QUIET_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	function automatic cmd_word_t noise_word();
		cmd_word_t c;
		c = {5'($urandom), $urandom, $urandom, $urandom, $urandom, 2'($urandom), $urandom};
		return c;
	endfunction

	function automatic cmd_word_t write_word(logic [3:0] idx, sect_entry_t e);
		cmd_word_t c;
		c = noise_word();
		c.op = OP_WRITE;
		c.entry_index = idx;
		c.entry_virt_start = e.virt_start;
		c.entry_virt_size = e.virt_size;
		c.entry_raw_start = e.raw_start;
		c.entry_raw_size = e.raw_size;
		return c;
	endfunction

	function automatic cmd_word_t xlate_word(logic [1:0] kind, logic [31:0] addr);
		cmd_word_t c;
		c = noise_word();
		c.op = OP_XLATE;
		c.addr_kind = kind;
		c.query_addr = addr;
		return c;
	endfunction

	function automatic sect_entry_t random_entry();
		sect_entry_t e;
		e.virt_start = $urandom_range(0, 63) << 12;
		e.virt_size = $urandom_range(0, 32'h2FFF);
		e.raw_start = $urandom_range(0, 255) << 9;
		e.raw_size = $urandom_range(0, 32'h2FFF);
		case ($urandom_range(0, 9))
			0: begin
				e = {$urandom, $urandom, $urandom, $urandom};
			end
			1: begin
				e.virt_size = '0;
				e.raw_size = '0;
			end
			2: begin
				e.virt_start = 32'hFFFF_FFFF - $urandom_range(0, 32'hFFF);
				e.raw_start = 32'hFFFF_FFFF - $urandom_range(0, 32'hFFF);
			end
			3: begin
				e.virt_size = '1;
				e.raw_size = '1;
			end
			default: begin
			end
		endcase
		return e;
	endfunction

	// Translations are only issued once every entry they may read is loaded.
	function automatic cmd_word_t next_command();
		sect_entry_t e;
		int          span;
		int          missing;
		int unsigned pick;
		logic [1:0]  kind;
		logic [31:0] lo;
		logic [31:0] len;
		logic [31:0] addr;
		span = (count_now > NUM_SECTIONS) ? NUM_SECTIONS : count_now;
		if (span == 0) begin
			span = 1;
		end
		missing = -1;
		for (int i = span - 1; i >= 0; i--) begin
			if (!loaded[i]) begin
				missing = i;
			end
		end
		if ($urandom_range(0, 99) < 18) begin
			return write_word(4'($urandom), random_entry());
		end
		pick = $urandom_range(0, 24);
		case (pick % 3)
			0: kind = KIND_VA;
			1: kind = KIND_RVA;
			default: kind = KIND_FO;
		endcase
		if (pick == 0) begin
			return xlate_word(KIND_UNKNOWN, $urandom);
		end
		if (missing >= 0) begin
			return write_word(4'(missing), random_entry());
		end
		e = layout[$urandom_range(0, span - 1)];
		case (kind)
			KIND_VA: begin
				lo = base_now + e.virt_start;
				len = e.virt_size;
			end
			KIND_RVA: begin
				lo = e.virt_start;
				len = e.virt_size;
			end
			default: begin
				lo = e.raw_start;
				len = e.raw_size;
			end
		endcase
		case ($urandom_range(0, 11))
			0: addr = lo;
			1: addr = lo + len;
			2: addr = lo + len + 1;
			3: addr = lo - 1;
			4: addr = $urandom;
			5: addr = '0;
			6: addr = '1;
			default: addr = lo + $urandom_range(0, len);
		endcase
		return xlate_word(kind, addr);
	endfunction

	task automatic send_command(cmd_word_t c);
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		if (c.op == OP_WRITE) begin
			layout[c.entry_index] = {c.entry_virt_start, c.entry_virt_size,
				c.entry_raw_start, c.entry_raw_size};
			loaded[c.entry_index] = 1'b1;
		end
		@(negedge clk);
		if ($urandom_range(0, 39) == 0) begin
			idle_enabled = !idle_enabled;
		end
		if (idle_allowed && idle_enabled && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
	endtask

	task automatic write_register(logic sel, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic reconfigure(logic [31:0] base, logic [4:0] count);
		start <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_register(REG_IMAGE_BASE, base);
		write_register(REG_SECTION_COUNT, {27'd0, count});
		base_now = base;
		count_now = count;
	endtask

	initial begin
		logic [31:0] base;
		logic [4:0]  count;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		loaded = '0;
		base_now = '0;
		count_now = '0;
		idle_enabled = 1'b1;
		idle_allowed = 1'b1;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_command(xlate_word(KIND_UNKNOWN, 32'hFFFF_FFFF));
		send_command(write_word(4'd0, {32'h1000, 32'h1FFF, 32'h400, 32'h1800}));
		send_command(xlate_word(KIND_VA, 32'h1000));
		send_command(xlate_word(KIND_RVA, 32'h2FFF));
		send_command(xlate_word(KIND_FO, 32'h400));
		send_command(write_word(4'd1, {32'h3000, 32'h0, 32'h2000, 32'h0}));
		send_command(write_word(4'd2, {32'hFFFF_F000, 32'h2000, 32'h0, 32'hFFFF_FFFF}));
		send_command(write_word(4'd15, {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF}));
		reconfigure(32'h0040_0000, 5'd3);
		send_command(xlate_word(KIND_RVA, 32'h1000));
		send_command(xlate_word(KIND_RVA, 32'h2FFF));
		send_command(xlate_word(KIND_RVA, 32'h3000));
		send_command(xlate_word(KIND_RVA, 32'h3001));
		send_command(xlate_word(KIND_VA, 32'h0040_1000));
		send_command(xlate_word(KIND_VA, 32'h0));
		send_command(xlate_word(KIND_FO, 32'h0));
		send_command(xlate_word(KIND_FO, 32'h400));
		send_command(xlate_word(KIND_FO, 32'hFFFF_FFFF));
		send_command(xlate_word(KIND_FO, 32'h2000));
		send_command(xlate_word(KIND_UNKNOWN, 32'h0));

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin
					base = 32'hFFFF_FFFF;
					count = 5'd16;
				end
				1: begin
					base = 32'h0;
					count = 5'd31;
				end
				2: begin
					base = $urandom;
					count = 5'd1;
				end
				3: begin
					base = 32'h0040_0000;
					count = 5'd0;
				end
				4: begin
					base = $urandom;
					count = 5'd17;
				end
				5: begin
					base = $urandom;
					count = 5'($urandom_range(2, 15));
				end
				6: begin
					base = 32'h0040_0000;
					count = 5'd8;
				end
				default: begin
					base = $urandom;
					count = 5'd16;
				end
			endcase
			reconfigure(base, count);
			idle_allowed = (phase != NUM_PHASES - 1);
			repeat (ITEMS_PER_PHASE) begin
				send_command(next_command());
			end
		end

		start <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/sat_pkg.sv
rtl/sat_sect_ram.sv
rtl/section_address_translator.sv
rtl/sat_checker.sv
tb/sv/sat_checker.sv
tb/sv/testbench.sv
